// ----- rtl/core/dcdr_pkg.sv -----
// Shared types and constants for the DC droop voltage reference unit.
package dcdr_pkg;

    localparam int VoltW   = 16;
    localparam int CurW    = 16;
    localparam int SlopeW  = 16;
    localparam int PowerW  = 20;
    localparam int MinCurW = 15;
    localparam int NumW    = 42;
    localparam int DenW    = 31;
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 20;
    localparam int OutDatW = 40;

    localparam logic [CfgIdxW-1:0] CfgNoLoadVoltage = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgDroopSlope    = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgPowerLimit    = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgMinCurrent    = 3'd3;

    localparam logic [VoltW-1:0]   RstNoLoadVoltage = 16'd6144;
    localparam logic [SlopeW-1:0]  RstDroopSlope    = 16'hECCD;
    localparam logic [PowerW-1:0]  RstPowerLimit    = 20'd25600;
    localparam logic [MinCurW-1:0] RstMinCurrent    = 15'd102;

    localparam logic [VoltW-1:0] VoltMax = 16'hFFFF;

    typedef struct packed {
        logic            start;
        logic [NumW-1:0] num;
        logic [DenW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [VoltW-1:0] quot;
    } t_div_rsp;

endpackage

// ----- rtl/core/dcdr_div.sv -----
// Restoring divider with a 16-bit saturated quotient, one quotient bit per cycle.
module dcdr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dcdr_pkg::t_div_req i_req,
    output dcdr_pkg::t_div_rsp o_rsp
);
    import dcdr_pkg::*;

    logic              r_chk;
    logic              r_busy;
    logic              r_done;
    logic [NumW-1:0]   r_num;
    logic [DenW-1:0]   r_den;
    logic [DenW:0]     r_rem;
    logic [VoltW-1:0]  r_q;
    logic [3:0]        r_cnt;

    logic [DenW:0]     n_trial;
    logic              n_fit;
    logic [DenW+16:0]  n_limit;

    always_comb begin
        n_trial = {r_rem[DenW-1:0], r_num[VoltW-1]};
        n_fit   = (n_trial >= {1'b0, r_den});
        n_limit = {1'b0, r_den, 16'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk  <= 1'b0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_chk <= 1'b1;
                r_num <= i_req.num;
                r_den <= i_req.den;
            end else if (r_chk) begin
                r_chk <= 1'b0;
                // A quotient of 2^16 or more saturates without iterating.
                if ({6'b0, r_num} >= n_limit) begin
                    r_q    <= VoltMax;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= {6'b0, r_num[NumW-1:VoltW]};
                    r_cnt  <= 4'd15;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= n_fit ? (n_trial - {1'b0, r_den}) : n_trial;
                r_q   <= {r_q[VoltW-2:0], n_fit};
                r_num <= {r_num[NumW-2:0], 1'b0};
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

// ----- rtl/core/dc_droop_voltage_reference_unit.sv -----
// Top level: droop voltage reference with power limit, sequenced over a shared divider.
// Below the minimum current a sample goes straight to the output; otherwise the slope product
// and denominator come first, then one division (none if the denominator fails) and a second
// when the power clamp applies. One sample at a time; the next waits until the result is loaded.
// Reset (synchronous, active low) loads the default registers, clears the stored power
// and empties the output register.
module dc_droop_voltage_reference_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [dcdr_pkg::CurW-1:0]     i_s_tdata,   // [15:0] current_sample
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [15:0] voltage_reference, [35:16] terminal_power, [36] power_limited,
    // [37] denominator_fault, [39:38] zero
    output logic [dcdr_pkg::OutDatW-1:0]  o_m_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dcdr_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [dcdr_pkg::CfgDatW-1:0]  i_cfg_data
);
    import dcdr_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DEN  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_PWR  = 3'd4;
    localparam logic [2:0] S_CMP  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]          r_state;
    logic                r_phase;
    logic [VoltW-1:0]    r_no_load_voltage;
    logic [SlopeW-1:0]   r_droop_slope;
    logic [PowerW-1:0]   r_power_limit;
    logic [MinCurW-1:0]  r_min_current;
    logic [PowerW-1:0]   r_last_power;
    logic [CurW-1:0]     r_cur;
    logic signed [33:0]  r_prod;
    logic [VoltW-1:0]    r_volt;
    logic [PowerW-1:0]   r_pwr;
    logic                r_lim;
    logic                r_fault;
    logic                r_m_valid;
    logic [OutDatW-1:0]  r_m_data;

    logic signed [16:0]  n_mul_a;
    logic signed [16:0]  n_mul_b;
    logic signed [33:0]  n_mul;
    logic signed [34:0]  n_den;
    logic                n_den_ok;
    logic [31:0]         n_psum;
    logic                n_over;
    logic                n_low;
    logic                n_acc;
    logic                n_load;
    t_div_req            n_req;
    t_div_rsp            n_rsp;

    dcdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_req),
        .o_rsp   (n_rsp)
    );

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;

    always_comb begin
        n_acc  = i_s_tvalid && o_s_tready;
        n_load = (r_state == S_OUT) && (!r_m_valid || i_m_tready);
        n_low  = $signed(i_s_tdata) < $signed({1'b0, r_min_current});
        // The one multiplier serves the slope product first and the power product later.
        if (r_state == S_MUL) begin
            n_mul_a = {r_cur[CurW-1], r_cur};
            n_mul_b = {r_droop_slope[SlopeW-1], r_droop_slope};
        end else begin
            n_mul_a = {1'b0, r_volt};
            n_mul_b = {2'b0, r_cur[MinCurW-1:0]};
        end
        n_mul    = n_mul_a * n_mul_b;
        n_den    = 35'sd33554432 - {r_prod[33], r_prod};
        n_den_ok = !n_den[34] && (n_den != 35'sd0);
        n_psum   = r_prod[31:0] + 32'd512;
        n_over   = ({2'b0, r_power_limit} <= n_psum[31:10]);

        n_req = '0;
        if (r_state == S_DEN && n_den_ok) begin
            n_req.start = 1'b1;
            n_req.den   = n_den[DenW-1:0];
            n_req.num   = {r_no_load_voltage, 26'b0} >> 1;
            n_req.num   = n_req.num + {12'b0, n_den[DenW-1:1]};
        end else if (r_state == S_CMP && n_over) begin
            n_req.start = 1'b1;
            n_req.den   = {16'b0, r_cur[MinCurW-1:0]};
            n_req.num   = {12'b0, r_power_limit, 10'b0}
                        + {28'b0, r_cur[MinCurW-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_no_load_voltage <= RstNoLoadVoltage;
            r_droop_slope     <= RstDroopSlope;
            r_power_limit     <= RstPowerLimit;
            r_min_current     <= RstMinCurrent;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CfgNoLoadVoltage: r_no_load_voltage <= i_cfg_data[VoltW-1:0];
                CfgDroopSlope:    r_droop_slope     <= i_cfg_data[SlopeW-1:0];
                CfgPowerLimit:    r_power_limit     <= i_cfg_data[PowerW-1:0];
                CfgMinCurrent:    r_min_current     <= i_cfg_data[MinCurW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_m_valid    <= 1'b0;
            r_last_power <= '0;
        end else begin
            if (r_m_valid && i_m_tready && !n_load) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_acc) begin
                        r_cur   <= i_s_tdata;
                        r_lim   <= 1'b0;
                        r_fault <= 1'b0;
                        r_phase <= 1'b0;
                        if (n_low) begin
                            r_volt  <= r_no_load_voltage;
                            r_pwr   <= r_last_power;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= n_mul;
                    r_state <= S_DEN;
                end
                S_DEN: begin
                    if (n_den_ok) begin
                        r_state <= S_DIV;
                    end else begin
                        r_volt  <= VoltMax;
                        r_fault <= 1'b1;
                        r_state <= S_PWR;
                    end
                end
                S_DIV: begin
                    if (n_rsp.done) begin
                        r_volt  <= n_rsp.quot;
                        r_state <= r_phase ? S_OUT : S_PWR;
                    end
                end
                S_PWR: begin
                    r_prod  <= n_mul;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (n_over) begin
                        r_pwr   <= r_power_limit;
                        r_lim   <= 1'b1;
                        r_phase <= 1'b1;
                        r_state <= S_DIV;
                    end else begin
                        r_pwr   <= n_psum[PowerW+9:10];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (n_load) begin
                        r_m_valid    <= 1'b1;
                        r_m_data     <= {2'b0, r_fault, r_lim, r_pwr, r_volt};
                        r_last_power <= r_pwr;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- dv/tb_dc_droop_voltage_reference_unit.sv -----
// Testbench for the droop voltage reference unit: directed plan, then randomized traffic.
`timescale 1ns / 1ps

module tb_dc_droop_voltage_reference_unit;
    import dcdr_pkg::*;

    typedef longint unsigned t_u64;

    typedef struct packed {
        logic [15:0] volt;
        logic [19:0] power;
        logic        limited;
        logic        fault;
    } t_droop_result;

    typedef enum logic {
        StepSample,
        StepWrite
    } t_step_kind;

    typedef struct packed {
        t_step_kind    kind;
        logic [2:0]    index;
        logic [19:0]   data;
        logic [15:0]   cur;
        logic          typed;
        t_droop_result want;
    } t_step;

    localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;
    localparam logic [15:0]        FullScale  = 16'hFFFF;
    localparam longint             UnityQ25   = 64'sd1 << 25;
    localparam int                 PlanLen    = 29;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [CurW-1:0]      i_s_tdata;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [OutDatW-1:0]   o_m_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CfgIdxW-1:0]   i_cfg_index;
    logic [CfgDatW-1:0]   i_cfg_data;

    // Register copies and stored power as the block should hold them.
    logic [15:0]          cfg_no_load     = 16'd6144;
    logic signed [15:0]   cfg_slope       = -16'sd4915;
    logic [19:0]          cfg_power_limit = 20'd25600;
    logic [14:0]          cfg_min_current = 15'd102;
    logic [19:0]          stored_power    = 20'd0;

    t_droop_result        pending_results [$];
    int                   fail_count      = 0;
    int                   send_gap_pct    = 0;
    int                   sink_stall_pct  = 0;

    // The typed expectations follow from the low-current bypass, the saturated reference
    // on a failed denominator, a zero no-load voltage, and the clamp with zero limit at currents 0 and 1.
    t_step plan [0:PlanLen-1] = '{
        '{StepSample, '0, '0, 16'h8000, 1'b1, '{16'd6144, 20'd0, 1'b0, 1'b0}},
        '{StepSample, '0, '0, 16'd0, 1'b1, '{16'd6144, 20'd0, 1'b0, 1'b0}},
        '{StepSample, '0, '0, 16'd101, 1'b1, '{16'd6144, 20'd0, 1'b0, 1'b0}},
        '{StepSample, '0, '0, 16'd102, 1'b0, '0},
        '{StepSample, '0, '0, 16'd1024, 1'b0, '0},
        '{StepSample, '0, '0, 16'd32767, 1'b0, '0},
        '{StepSample, '0, '0, 16'd50, 1'b1, '{16'd6144, 20'd25600, 1'b0, 1'b0}},
        '{StepWrite, CfgDroopSlope, 20'h07FFF, '0, 1'b0, '0},
        '{StepSample, '0, '0, 16'd1024, 1'b0, '0},
        '{StepSample, '0, '0, 16'd2048, 1'b1, '{16'd12800, 20'd25600, 1'b1, 1'b1}},
        '{StepWrite, CfgPowerLimit, 20'hFFFFF, '0, 1'b0, '0},
        '{StepSample, '0, '0, 16'd32767, 1'b0, '0},
        '{StepSample, '0, '0, 16'd1100, 1'b0, '0},
        '{StepWrite, CfgNoLoadVoltage, 20'hF0000, '0, 1'b0, '0},
        '{StepWrite, CfgDroopSlope, 20'hF8000, '0, 1'b0, '0},
        '{StepSample, '0, '0, 16'd500, 1'b1, '{16'd0, 20'd0, 1'b0, 1'b0}},
        '{StepWrite, CfgNoLoadVoltage, 20'h0FFFF, '0, 1'b0, '0},
        '{StepWrite, CfgSpareLo, 20'h12345, '0, 1'b0, '0},
        '{StepWrite, CfgSpareHi, 20'hFFFFF, '0, 1'b0, '0},
        '{StepSample, '0, '0, 16'd32767, 1'b0, '0},
        '{StepWrite, CfgMinCurrent, 20'hF8000, '0, 1'b0, '0},
        '{StepWrite, CfgPowerLimit, 20'h00000, '0, 1'b0, '0},
        '{StepSample, '0, '0, 16'd0, 1'b1, '{16'hFFFF, 20'd0, 1'b1, 1'b0}},
        '{StepSample, '0, '0, 16'hFFFF, 1'b1, '{16'hFFFF, 20'd0, 1'b0, 1'b0}},
        '{StepSample, '0, '0, 16'd1, 1'b1, '{16'd0, 20'd0, 1'b1, 1'b0}},
        '{StepWrite, CfgMinCurrent, 20'h07FFF, '0, 1'b0, '0},
        '{StepWrite, CfgPowerLimit, 20'd25600, '0, 1'b0, '0},
        '{StepSample, '0, '0, 16'd32766, 1'b1, '{16'hFFFF, 20'd0, 1'b0, 1'b0}},
        '{StepSample, '0, '0, 16'd32767, 1'b0, '0}
    };

    dc_droop_voltage_reference_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [15:0] clamp_volt(input t_u64 v);
        return (v > 64'd65535) ? FullScale : v[15:0];
    endfunction

    function automatic void apply_register(input logic [2:0] index, input logic [19:0] data);
        case (index)
            CfgNoLoadVoltage: cfg_no_load     = data[15:0];
            CfgDroopSlope:    cfg_slope       = data[15:0];
            CfgPowerLimit:    cfg_power_limit = data[19:0];
            CfgMinCurrent:    cfg_min_current = data[14:0];
            default: ;
        endcase
    endfunction

    function automatic t_droop_result predict_reference(input logic [15:0] sample);
        int            c;
        longint        den;
        t_u64          quo;
        t_u64          pw;
        t_u64          icur;
        t_droop_result r;
        r = '0;
        c = $signed(sample);
        if (c < int'(cfg_min_current)) begin
            r.volt  = cfg_no_load;
            r.power = stored_power;
            return r;
        end
        icur = t_u64'(c);
        // The denominator is exact in Q.25; current times slope cannot overflow here.
        den = UnityQ25 - longint'(c) * longint'(cfg_slope);
        if (den <= 0) begin
            r.volt  = FullScale;
            r.fault = 1'b1;
        end else begin
            quo    = ((t_u64'(cfg_no_load) << 25) + (t_u64'(den) >> 1)) / t_u64'(den);
            r.volt = clamp_volt(quo);
        end
        pw = (t_u64'(r.volt) * icur + 64'd512) >> 10;
        if (pw >= t_u64'(cfg_power_limit)) begin
            r.power   = cfg_power_limit;
            r.limited = 1'b1;
            if (icur == 0) begin
                r.volt = FullScale;
            end else begin
                r.volt = clamp_volt(((t_u64'(cfg_power_limit) << 10) + (icur >> 1)) / icur);
            end
        end else begin
            r.power = pw[19:0];
        end
        stored_power = r.power;
        return r;
    endfunction

    // Mostly positive currents around the operating range, some near the bypass threshold,
    // and a share of arbitrary codes.
    function automatic logic [15:0] pick_current();
        int near;
        case ($urandom_range(0, 9))
            0, 1: return 16'($urandom());
            2, 3: begin
                near = int'(cfg_min_current) + int'($urandom_range(0, 8)) - 4;
                return 16'(near);
            end
            9: return 16'($urandom_range(8192, 32767));
            default: return 16'($urandom_range(0, 8191));
        endcase
    endfunction

    task automatic cfg_write(input logic [2:0] index, input logic [19:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(index, data);
    endtask

    task automatic send_sample(input logic [15:0] cur, input logic typed,
                               input t_droop_result want);
        t_droop_result predicted;
        i_cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= cur;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = predict_reference(cur);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Stop feeding and wait until every result is back, so registers can be written.
    task automatic settle();
        i_s_tvalid  <= 1'b0;
        i_cfg_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_setting();
        logic [19:0] word [4];
        for (int k = 0; k < 4; k++) word[k] = 20'($urandom());
        case ($urandom_range(0, 3))
            0: begin
                word[0][15:0] = 16'd6144;
                word[1][15:0] = 16'hECCD;
                word[2]       = 20'd25600;
                word[3][14:0] = 15'd102;
            end
            1: begin
                word[0][15:0] = 16'($urandom_range(512, 16384));
                word[1][15:0] = 16'(0 - $urandom_range(0, 8192));
                word[2]       = 20'($urandom_range(256, 65535));
                word[3][14:0] = 15'($urandom_range(1, 1024));
            end
            2: ;
            default: begin
                word[0][15:0] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                word[1][15:0] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                word[2]       = $urandom_range(0, 1) ? 20'hFFFFF : 20'h00000;
                word[3][14:0] = $urandom_range(0, 1) ? 15'h7FFF : 15'(word[3][0]);
            end
        endcase
        cfg_write(CfgNoLoadVoltage, word[0]);
        cfg_write(CfgDroopSlope, word[1]);
        cfg_write(CfgPowerLimit, word[2]);
        cfg_write(CfgMinCurrent, word[3]);
        if ($urandom_range(0, 3) == 0) begin
            cfg_write(3'($urandom_range(CfgSpareLo, CfgSpareHi)), 20'($urandom()));
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_droop_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item: tdata %h", o_m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                // tdata: [15:0] reference, [35:16] power, [36] clamp, [37] fault, [39:38] pad
                if (o_m_tdata[15:0] !== want.volt) begin
                    $error("voltage_reference: expected %0d, got %0d",
                           want.volt, o_m_tdata[15:0]);
                    fail_count++;
                end
                if (o_m_tdata[35:16] !== want.power) begin
                    $error("terminal_power: expected %0d, got %0d",
                           want.power, o_m_tdata[35:16]);
                    fail_count++;
                end
                if (o_m_tdata[36] !== want.limited) begin
                    $error("power_limited: expected %0d, got %0d", want.limited, o_m_tdata[36]);
                    fail_count++;
                end
                if (o_m_tdata[37] !== want.fault) begin
                    $error("denominator_fault: expected %0d, got %0d",
                           want.fault, o_m_tdata[37]);
                    fail_count++;
                end
                if (o_m_tdata[39:38] !== 2'b00) begin
                    $error("pad: expected 0, got %0d", o_m_tdata[39:38]);
                    fail_count++;
                end
            end
        end
        i_m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    initial begin : stimulus
        logic prev_write;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        prev_write  = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < PlanLen; k++) begin
            if (plan[k].kind == StepWrite) begin
                if (!prev_write) settle();
                cfg_write(plan[k].index, plan[k].data);
            end else begin
                send_sample(plan[k].cur, plan[k].typed, plan[k].want);
            end
            prev_write = (plan[k].kind == StepWrite);
        end

        // Sender dense and receiver busy, then the reverse, then full rate both ways.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_gap_pct   = 12;
                    sink_stall_pct = 85;
                end
                1: begin
                    send_gap_pct   = 85;
                    sink_stall_pct = 12;
                end
                default: begin
                    send_gap_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            repeat (5) begin
                settle();
                write_setting();
                repeat (104) send_sample(pick_current(), 1'b0, '0);
            end
        end

        settle();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** dc_droop_voltage_reference_unit: PASSED **");
        end else begin
            $display("** dc_droop_voltage_reference_unit: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("** dc_droop_voltage_reference_unit: FAILED **");
        $finish;
    end

endmodule
